>>> design/gha_pkg.sv
// Shared types and constants for the generational entity handle allocator.
package gha_pkg;

  // Slot storage size and the index width that follows from it.
  localparam int SLOTS  = 256;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed field widths of the handle and the configuration registers.
  localparam int HANDLE_W       = 32;
  localparam int HSLOT_W        = 16;
  localparam int GEN_W          = 8;
  localparam int TYPE_W         = 8;
  localparam int ENTITY_LIMIT_W = 9;
  localparam int STATUS_W       = 2;

  // Effective limit width holds values up to max(SLOTS, 511).
  localparam int LIM_W = (SLOT_W + 1 > ENTITY_LIMIT_W) ? SLOT_W + 1 : ENTITY_LIMIT_W;
  // Width used when comparing a 16-bit handle slot against the limit.
  localparam int CMP_W = (LIM_W > HSLOT_W) ? LIM_W : HSLOT_W;

  // Null handle returned when no slot is free.
  localparam logic [HANDLE_W-1:0] NULL_HANDLE = 32'hFFFF_FFFF;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ENTITY_LIMIT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTITY_LIMIT = 2'd1;

  localparam logic [ENTITY_LIMIT_W-1:0] ENTITY_LIMIT_RST = 9'd256;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic {
    MODE_CREATE = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Lookup result from the slot map for the item being accepted.
  typedef struct packed {
    logic      found;      // a free slot exists below the limit
    slot_idx_t free_slot;  // lowest free slot below the limit
    logic      del_range;  // delete slot at or above the limit
    logic      del_free;   // delete slot is already free
    slot_idx_t del_slot;   // delete slot truncated to the index width
  } slot_info_t;

endpackage

>>> design/gha_if.sv
// Item channel interfaces: request, result and configuration write.
interface gha_req_if;
  import gha_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [HANDLE_W-1:0] handle_in;

  modport source (output valid, output mode, output handle_in, input ready);
  modport sink   (input valid, input mode, input handle_in, output ready);
endinterface

interface gha_rsp_if;
  import gha_pkg::*;
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] handle_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output handle_out, output status, input ready);
  modport sink   (input valid, input handle_out, input status, output ready);
endinterface

interface gha_cfg_if;
  import gha_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/gha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/gha_slot_map.sv
// Free-slot bitmap with lowest-free-slot search and delete range checks.
module gha_slot_map import gha_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ENTITY_LIMIT_W-1:0] entity_limit,
  input  logic                      take,
  input  logic                      mode,
  input  logic [HSLOT_W-1:0]        req_slot,
  output slot_info_t                info
);

  logic [SLOTS-1:0] free_map;
  logic [LIM_W-1:0] lim;
  logic [SLOTS-1:0] cand;
  logic [CMP_W-1:0] req_slot_ext;

  // Effective limit saturates at the number of slots.
  always_comb begin
    lim = LIM_W'(entity_limit);
    if (lim > LIM_W'(SLOTS)) begin
      lim = LIM_W'(SLOTS);
    end
  end

  // A slot is a candidate when it is free and below the limit.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cand[i] = free_map[i] && (LIM_W'(i) < lim);
    end
  end

  // Priority encoder: the lowest candidate wins.
  always_comb begin
    info.found     = 1'b0;
    info.free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        info.found     = 1'b1;
        info.free_slot = SLOT_W'(i);
      end
    end
  end

  // Delete checks against the limit and the map.
  always_comb begin
    req_slot_ext   = CMP_W'(req_slot);
    info.del_slot  = req_slot[SLOT_W-1:0];
    info.del_range = (req_slot_ext >= CMP_W'(lim));
    info.del_free  = free_map[info.del_slot];
  end

  // Map update: a create that finds a slot claims it, a valid delete releases one.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else if (take) begin
      if (mode == MODE_CREATE) begin
        if (info.found) begin
          free_map[info.free_slot] <= 1'b0;
        end
      end else if (!info.del_range && !info.del_free) begin
        free_map[info.del_slot] <= 1'b1;
      end
    end
  end

endmodule

>>> design/generational_entity_handle_allocator.sv
// A result passes through stage B and the result register after its item is accepted.
// Throughput: one item per cycle; the free-map priority encoder and the
// generation RAM read set the cycle, and stalls come only from the result side.
// Reset: every slot is free, type_id is 0 and entity_limit is 256. Generations
// read as zero through per-slot valid bits, so no clearing pass is needed.
module generational_entity_handle_allocator import gha_pkg::*; (
  input logic   clk,
  input logic   rst,
  gha_req_if.sink   req,
  gha_rsp_if.source rsp,
  gha_cfg_if.sink   cfg
);

  logic [TYPE_W-1:0]         type_id;
  logic [ENTITY_LIMIT_W-1:0] entity_limit;

  logic       accept;
  slot_info_t info;
  status_t    status_a;
  slot_idx_t  slot_a;

  // Stage B: item waiting on the generation read.
  logic                b_valid;
  logic                b_mode;
  logic [HANDLE_W-1:0] b_handle;
  status_t             b_status;
  slot_idx_t           b_slot;
  logic                b_gvalid;
  logic [TYPE_W-1:0]   b_type;
  logic                b_advance;

  // Generation store and its per-slot valid bits.
  logic [SLOTS-1:0]    gen_valid;
  logic [GEN_W-1:0]    gen_rdata;
  logic [GEN_W-1:0]    gen_next;
  logic                gen_we;

  // Result register.
  logic                out_valid;
  logic [HANDLE_W-1:0] handle_out;
  status_t             status;
  logic [HANDLE_W-1:0] handle_b;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_id      <= '0;
      entity_limit <= ENTITY_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TYPE_ID:      type_id      <= cfg.data[TYPE_W-1:0];
        CFG_ENTITY_LIMIT: entity_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // Handshake: stage B moves on when the result register is free or drains.
  assign b_advance = !out_valid || rsp.ready;
  assign req.ready = !b_valid || b_advance;
  assign accept    = req.valid && req.ready;

  gha_slot_map u_slot_map (
    .clk          (clk),
    .rst          (rst),
    .entity_limit (entity_limit),
    .take         (accept),
    .mode         (req.mode),
    .req_slot     (req.handle_in[HSLOT_W-1:0]),
    .info         (info)
  );

  // Status and slot of the accepted item.
  always_comb begin
    if (req.mode == MODE_CREATE) begin
      slot_a   = info.free_slot;
      status_a = info.found ? ST_DONE : ST_NONE;
    end else begin
      slot_a = info.del_slot;
      if (info.del_range) begin
        status_a = ST_RANGE;
      end else if (info.del_free) begin
        status_a = ST_NONE;
      end else begin
        status_a = ST_DONE;
      end
    end
  end

  // Generation RAM: read on accept, written back as a successful create leaves stage B.
  assign gen_next = (b_gvalid ? gen_rdata : '0) + GEN_W'(1);
  assign gen_we   = b_valid && b_advance && (b_mode == MODE_CREATE) && (b_status == ST_DONE);

  gha_ram #(
    .WIDTH (GEN_W),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (b_slot),
    .wdata (gen_next),
    .re    (accept),
    .raddr (slot_a),
    .rdata (gen_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid <= '0;
    end else if (gen_we) begin
      gen_valid[b_slot] <= 1'b1;
    end
  end

  // Stage B control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (req.ready) begin
      b_valid <= req.valid;
    end
  end

  // Stage B payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_mode   <= req.mode;
      b_handle <= req.handle_in;
      b_status <= status_a;
      b_slot   <= slot_a;
      b_gvalid <= gen_valid[slot_a];
      b_type   <= type_id;
    end
  end

  // Result handle assembly.
  always_comb begin
    if (b_mode == MODE_DELETE) begin
      handle_b = b_handle;
    end else if (b_status == ST_DONE) begin
      handle_b = {gen_next, b_type, HSLOT_W'(b_slot)};
    end else begin
      handle_b = NULL_HANDLE;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_advance) begin
      out_valid <= b_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (b_advance && b_valid) begin
      handle_out <= handle_b;
      status     <= b_status;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.handle_out = handle_out;
  assign rsp.status     = status;

endmodule
